>>> rtl/urtb_pkg.sv
// ----------------------------------------------------------------------------
// urtb_pkg
// Shared sizes, codes and cell control types for the undo/redo text buffer.
// ----------------------------------------------------------------------------
package urtb_pkg;

    // storage sizes
    localparam int TEXT_DEPTH    = 64;
    localparam int HISTORY_DEPTH = 128;

    // counter widths, wide enough to hold the depth itself
    localparam int TCW = $clog2(TEXT_DEPTH + 1);
    localparam int HCW = $clog2(HISTORY_DEPTH + 1);

    // fixed payload widths
    localparam int CMD_W    = 2;
    localparam int CHAR_W   = 8;
    localparam int STATUS_W = 3;
    localparam int TLEN_W   = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_UNDO   = 2'd1,
        CMD_REDO   = 2'd2,
        CMD_PRINT  = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_UNDO_EMPTY = 3'd1,
        ST_REDO_EMPTY = 3'd2,
        ST_HIST_FULL  = 3'd3,
        ST_TEXT_FULL  = 3'd4,
        ST_TEXT_EMPTY = 3'd5
    } t_status;

    // history stack cell control
    typedef struct packed {
        logic push;
        logic pop;
    } t_stk_ctl;

    // text cell control
    typedef struct packed {
        logic wr;
        logic rot;
        logic wrap;
    } t_txt_ctl;

endpackage

>>> rtl/urtb_if.sv
// ----------------------------------------------------------------------------
// urtb_in_if / urtb_out_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface urtb_in_if import urtb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [CHAR_W-1:0] char_in;

    modport source (output valid, command, char_in, input ready);
    modport sink   (input valid, command, char_in, output ready);
endinterface

interface urtb_out_if import urtb_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [CHAR_W-1:0]   char_out;
    logic [TLEN_W-1:0]   text_length;
    logic                last;

    modport source (output valid, status, char_out, text_length, last, input ready);
    modport sink   (input valid, status, char_out, text_length, last, output ready);
endinterface

>>> rtl/undo_redo_text_buffer_top.sv
// ----------------------------------------------------------------------------
// undo_redo_text_buffer_top
// Text buffer with undo and redo history stacks built from cell chains.
// ----------------------------------------------------------------------------
// Insert, undo and redo each give one result item. Print gives one result
// item per character, oldest first, at one item per cycle while the output
// is taken (a single status item when the text is empty); the text chain
// rotates by one cell per printed character and is back in order when the
// last one leaves. No new command item is taken during a print.
// The history stacks are push-down chains with the top in the first cell; a
// push onto a full stack is dropped and flagged while the text still changes.
// A result waits in the output register until taken; a new item is taken in
// the same cycle in which the waiting result leaves. No clearing is needed
// after reset.
// ----------------------------------------------------------------------------
module undo_redo_text_buffer_top import urtb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    urtb_in_if.sink     i_in,
    urtb_out_if.source  o_out
);

    typedef enum logic {
        S_EDIT,
        S_PRINT
    } t_state;

    t_state              r_state, n_state;
    logic [TCW-1:0]      r_tc, n_tc;
    logic [HCW-1:0]      r_uc, n_uc;
    logic [HCW-1:0]      r_rc, n_rc;
    logic [TCW-1:0]      r_left, n_left;
    logic                r_ov, n_ov;
    t_status             r_status, n_status;
    logic [CHAR_W-1:0]   r_char, n_char;
    logic                r_last, n_last;

    logic                w_slot_free;
    logic                w_in_acc;
    t_stk_ctl            w_undo_ctl, w_redo_ctl;
    logic [CHAR_W-1:0]   w_undo_din, w_redo_din, w_text_din;
    logic                w_twr, w_trot;

    logic [CHAR_W-1:0]   w_undo [HISTORY_DEPTH];
    logic [CHAR_W-1:0]   w_redo [HISTORY_DEPTH];
    logic [CHAR_W-1:0]   w_text [TEXT_DEPTH];

    // handshake
    assign w_slot_free = !r_ov || o_out.ready;
    assign i_in.ready  = (r_state == S_EDIT) && w_slot_free;
    assign w_in_acc    = i_in.valid && i_in.ready;

    // command decode and next state
    always_comb begin
        n_state    = r_state;
        n_tc       = r_tc;
        n_uc       = r_uc;
        n_rc       = r_rc;
        n_left     = r_left;
        n_ov       = r_ov && !o_out.ready;
        n_status   = r_status;
        n_char     = r_char;
        n_last     = r_last;
        w_undo_ctl = '0;
        w_redo_ctl = '0;
        w_undo_din = i_in.char_in;
        w_redo_din = w_undo[0];
        w_text_din = i_in.char_in;
        w_twr      = 1'b0;
        w_trot     = 1'b0;
        case (r_state)
            S_EDIT: begin
                if (w_in_acc) begin
                    n_ov   = 1'b1;
                    n_last = 1'b1;
                    n_char = '0;
                    case (t_cmd'(i_in.command))
                        CMD_INSERT: begin
                            if (r_tc == TCW'(TEXT_DEPTH)) begin
                                n_status = ST_TEXT_FULL;
                            end else begin
                                w_twr  = 1'b1;
                                n_tc   = r_tc + 1'b1;
                                n_char = i_in.char_in;
                                if (r_uc == HCW'(HISTORY_DEPTH)) begin
                                    n_status = ST_HIST_FULL;
                                end else begin
                                    w_undo_ctl.push = 1'b1;
                                    n_uc     = r_uc + 1'b1;
                                    n_status = ST_OK;
                                end
                            end
                        end
                        CMD_UNDO: begin
                            if (r_uc == '0) begin
                                n_status = ST_UNDO_EMPTY;
                            end else begin
                                w_undo_ctl.pop = 1'b1;
                                n_uc   = r_uc - 1'b1;
                                n_char = w_undo[0];
                                if (r_tc != '0) begin
                                    n_tc = r_tc - 1'b1;
                                end
                                if (r_rc == HCW'(HISTORY_DEPTH)) begin
                                    n_status = ST_HIST_FULL;
                                end else begin
                                    w_redo_ctl.push = 1'b1;
                                    n_rc     = r_rc + 1'b1;
                                    n_status = ST_OK;
                                end
                            end
                        end
                        CMD_REDO: begin
                            w_undo_din = w_redo[0];
                            w_text_din = w_redo[0];
                            if (r_rc == '0) begin
                                n_status = ST_REDO_EMPTY;
                            end else if (r_tc == TCW'(TEXT_DEPTH)) begin
                                n_status = ST_TEXT_FULL;
                            end else begin
                                w_redo_ctl.pop = 1'b1;
                                n_rc   = r_rc - 1'b1;
                                w_twr  = 1'b1;
                                n_tc   = r_tc + 1'b1;
                                n_char = w_redo[0];
                                if (r_uc == HCW'(HISTORY_DEPTH)) begin
                                    n_status = ST_HIST_FULL;
                                end else begin
                                    w_undo_ctl.push = 1'b1;
                                    n_uc     = r_uc + 1'b1;
                                    n_status = ST_OK;
                                end
                            end
                        end
                        CMD_PRINT: begin
                            if (r_tc == '0) begin
                                n_status = ST_TEXT_EMPTY;
                            end else begin
                                n_ov    = 1'b0;
                                n_left  = r_tc;
                                n_state = S_PRINT;
                            end
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end
            S_PRINT: begin
                // emit the head cell and rotate the occupied text by one
                if (w_slot_free) begin
                    n_ov     = 1'b1;
                    n_status = ST_OK;
                    n_char   = w_text[0];
                    n_last   = (r_left == TCW'(1));
                    w_trot   = 1'b1;
                    n_left   = r_left - 1'b1;
                    if (r_left == TCW'(1)) begin
                        n_state = S_EDIT;
                    end
                end
            end
            default: begin
                n_state = S_EDIT;
            end
        endcase
    end

    // state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_EDIT;
            r_tc    <= '0;
            r_uc    <= '0;
            r_rc    <= '0;
            r_left  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_tc    <= n_tc;
            r_uc    <= n_uc;
            r_rc    <= n_rc;
            r_left  <= n_left;
            r_ov    <= n_ov;
        end
        r_status <= n_status;
        r_char   <= n_char;
        r_last   <= n_last;
    end

    // undo and redo stack chains
    for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_hist
        logic [CHAR_W-1:0] w_uprev, w_unext, w_rprev, w_rnext;
        if (i == 0) begin : g_top
            assign w_uprev = w_undo_din;
            assign w_rprev = w_redo_din;
        end else begin : g_mid
            assign w_uprev = w_undo[i-1];
            assign w_rprev = w_redo[i-1];
        end
        if (i == HISTORY_DEPTH - 1) begin : g_bot
            assign w_unext = w_undo[i];
            assign w_rnext = w_redo[i];
        end else begin : g_inner
            assign w_unext = w_undo[i+1];
            assign w_rnext = w_redo[i+1];
        end
        urtb_stack_cell u_undo (
            .i_clk  (i_clk),
            .i_ctl  (w_undo_ctl),
            .i_prev (w_uprev),
            .i_next (w_unext),
            .o_data (w_undo[i])
        );
        urtb_stack_cell u_redo (
            .i_clk  (i_clk),
            .i_ctl  (w_redo_ctl),
            .i_prev (w_rprev),
            .i_next (w_rnext),
            .o_data (w_redo[i])
        );
    end

    // text chain, head in cell zero
    for (genvar i = 0; i < TEXT_DEPTH; i++) begin : g_text
        t_txt_ctl          w_ctl;
        logic [CHAR_W-1:0] w_next;
        assign w_ctl.wr   = w_twr && (r_tc == TCW'(i));
        assign w_ctl.rot  = w_trot;
        assign w_ctl.wrap = (r_tc == TCW'(i + 1));
        if (i == TEXT_DEPTH - 1) begin : g_end
            assign w_next = w_text[i];
        end else begin : g_inner
            assign w_next = w_text[i+1];
        end
        urtb_text_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_wdata (w_text_din),
            .i_next  (w_next),
            .i_head  (w_text[0]),
            .o_data  (w_text[i])
        );
    end

    // result channel
    assign o_out.valid       = r_ov;
    assign o_out.status      = r_status;
    assign o_out.char_out    = r_char;
    assign o_out.text_length = TLEN_W'(r_tc);
    assign o_out.last        = r_last;

`ifndef SYNTHESIS
    // counters never pass their depth
    a_tc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tc <= TCW'(TEXT_DEPTH))
        else $error("text count beyond depth");
    a_hist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_uc <= HCW'(HISTORY_DEPTH)) && (r_rc <= HCW'(HISTORY_DEPTH)))
        else $error("history count beyond depth");
    // no command taken while printing
    a_print_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PRINT) |-> !i_in.ready)
        else $error("input ready during print");
    // text length holds through a print
    a_print_tc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PRINT) |=> $stable(r_tc))
        else $error("text changed during print");
    // print remainder stays within the text
    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PRINT) |-> (r_left != '0) && (r_left <= r_tc))
        else $error("print count out of range");
`endif

endmodule

>>> rtl/urtb_stack_cell.sv
// ----------------------------------------------------------------------------
// urtb_stack_cell
// One character of a history stack: shifts down on push, up on pop.
// ----------------------------------------------------------------------------
module urtb_stack_cell import urtb_pkg::*; (
    input  logic              i_clk,
    input  t_stk_ctl          i_ctl,
    input  logic [CHAR_W-1:0] i_prev,
    input  logic [CHAR_W-1:0] i_next,
    output logic [CHAR_W-1:0] o_data
);

    logic [CHAR_W-1:0] r_data;

    // push takes the cell above, pop takes the cell below
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_data <= i_prev;
        end else if (i_ctl.pop) begin
            r_data <= i_next;
        end
    end

    assign o_data = r_data;

endmodule

>>> rtl/urtb_text_cell.sv
// ----------------------------------------------------------------------------
// urtb_text_cell
// One character of the text: written at the end, rotated toward the head
// while the text is printed.
// ----------------------------------------------------------------------------
module urtb_text_cell import urtb_pkg::*; (
    input  logic              i_clk,
    input  t_txt_ctl          i_ctl,
    input  logic [CHAR_W-1:0] i_wdata,
    input  logic [CHAR_W-1:0] i_next,
    input  logic [CHAR_W-1:0] i_head,
    output logic [CHAR_W-1:0] o_data
);

    logic [CHAR_W-1:0] r_data;

    // last occupied cell takes the head back during rotation
    always_ff @(posedge i_clk) begin
        if (i_ctl.rot) begin
            r_data <= i_ctl.wrap ? i_head : i_next;
        end else if (i_ctl.wr) begin
            r_data <= i_wdata;
        end
    end

    assign o_data = r_data;

endmodule
